@@ rtl/slx_pkg.sv @@
// Shared types and constants for the shell command lexer.
// Depends on nothing; the front end, queue, back end and top level import it.
package slx_pkg;

  // Result kinds on the event channel
  localparam logic [2:0] K_BYTE   = 3'd0;
  localparam logic [2:0] K_WEND   = 3'd1;
  localparam logic [2:0] K_PIPE   = 3'd2;
  localparam logic [2:0] K_TRUNC  = 3'd3;
  localparam logic [2:0] K_APPEND = 3'd4;
  localparam logic [2:0] K_LINE   = 3'd5;
  localparam logic [2:0] K_INPUT  = 3'd6;

  // Bytes with a meaning to the lexer
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // One result
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } event_t;

  // All results of one item; an item with no result is never queued
  typedef struct packed {
    logic   two;   // second event is valid
    event_t ev0;
    event_t ev1;
  } entry_t;

endpackage

@@ rtl/slx_in_if.sv @@
// Input channel of the lexer: one byte or an end-of-input mark per item.
// Stand-alone; no package needed.
interface slx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

@@ rtl/slx_out_if.sv @@
// Output channel of the lexer: one event per item.
// Stand-alone; no package needed.
interface slx_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] word_byte;
  logic       last_of_run;

  modport source (output valid, output event_kind, output word_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input event_kind, input word_byte, input last_of_run,
                  output ready);
endinterface

@@ rtl/slx_front.sv @@
// Front end: accepts input items, runs the lexer state and classifies each
// item into zero, one or two events. Depends on slx_pkg and slx_in_if.
module slx_front (
  input  logic           clk,
  input  logic           rst,
  slx_in_if.sink         chars,
  input  logic           q_full,
  output logic           push,
  output slx_pkg::entry_t push_entry
);
  import slx_pkg::*;

  localparam logic [3:0] M_SKIP    = 4'd0;
  localparam logic [3:0] M_WORD    = 4'd1;
  localparam logic [3:0] M_ESC     = 4'd2;
  localparam logic [3:0] M_SQ      = 4'd3;
  localparam logic [3:0] M_DQ      = 4'd4;
  localparam logic [3:0] M_SQ_ESC  = 4'd5;
  localparam logic [3:0] M_DQ_ESC  = 4'd6;
  localparam logic [3:0] M_REDIR   = 4'd7;
  localparam logic [3:0] M_COMMENT = 4'd8;

  logic [3:0] mode, mode_next;
  logic       word_open, word_open_next;
  logic [1:0] n;
  event_t     evs [2];
  logic       fire;
  logic [7:0] c;
  logic [7:0] q;

  assign chars.ready = !q_full;
  assign fire        = chars.valid && !q_full;
  assign c           = chars.char_in;

  always_comb begin
    mode_next      = mode;
    word_open_next = word_open;
    n              = 2'd0;
    evs[0]         = '0;
    evs[1]         = '0;
    q              = (mode == M_SQ_ESC) ? CH_SQ : CH_DQ;
    if (chars.end_of_input) begin
      if (mode == M_REDIR) begin
        evs[n[0]] = '{kind: K_TRUNC, data: 8'd0};
        n = n + 2'd1;
      end
      if (word_open_next) begin
        evs[n[0]] = '{kind: K_WEND, data: 8'd0};
        n = n + 2'd1;
        word_open_next = 1'b0;
      end
      evs[n[0]] = '{kind: K_INPUT, data: 8'd0};
      n = n + 2'd1;
      mode_next = M_SKIP;
    end else begin
      unique case (mode)
        M_ESC: begin
          // tab, newline, VT, FF and CR are dropped; backslash-newline continues
          if (!(c >= CH_TAB && c <= CH_CR)) begin
            evs[0] = '{kind: K_BYTE, data: c};
            n = 2'd1;
            word_open_next = 1'b1;
          end
          mode_next = M_WORD;
        end
        M_SQ, M_DQ: begin
          if (c == CH_BSL) begin
            mode_next = (mode == M_SQ) ? M_SQ_ESC : M_DQ_ESC;
          end else if (c == ((mode == M_SQ) ? CH_SQ : CH_DQ)) begin
            mode_next = M_WORD;
          end else begin
            evs[0] = '{kind: K_BYTE, data: c};
            n = 2'd1;
            word_open_next = 1'b1;
          end
        end
        M_SQ_ESC, M_DQ_ESC: begin
          if (c == CH_BSL || c == q) begin
            evs[0] = '{kind: K_BYTE, data: c};
            n = 2'd1;
            word_open_next = 1'b1;
          end else if (c != CH_NL) begin
            evs[0] = '{kind: K_BYTE, data: CH_BSL};
            evs[1] = '{kind: K_BYTE, data: c};
            n = 2'd2;
            word_open_next = 1'b1;
          end
          mode_next = (mode == M_SQ_ESC) ? M_SQ : M_DQ;
        end
        M_REDIR: begin
          if (c == CH_GT) begin
            evs[0] = '{kind: K_APPEND, data: 8'd0};
            n = 2'd1;
            mode_next = M_SKIP;
          end else begin
            evs[0] = '{kind: K_TRUNC, data: 8'd0};
            n = 2'd1;
            if (c == CH_SPACE) begin
              mode_next = M_SKIP;
            end else begin
              evs[1] = '{kind: K_BYTE, data: c};
              n = 2'd2;
              word_open_next = 1'b1;
              mode_next = M_WORD;
            end
          end
        end
        M_COMMENT: begin
          if (c == CH_NL) begin
            evs[0] = '{kind: K_LINE, data: 8'd0};
            n = 2'd1;
            mode_next = M_SKIP;
          end
        end
        default: begin
          // skip-spaces and in-word modes; unused codes behave the same
          case (c)
            CH_SPACE, CH_PIPE, CH_GT, CH_HASH, CH_NL: begin
              if (word_open_next) begin
                evs[0] = '{kind: K_WEND, data: 8'd0};
                n = 2'd1;
                word_open_next = 1'b0;
              end
              if (c == CH_PIPE) begin
                evs[n[0]] = '{kind: K_PIPE, data: 8'd0};
                n = n + 2'd1;
              end else if (c == CH_NL) begin
                evs[n[0]] = '{kind: K_LINE, data: 8'd0};
                n = n + 2'd1;
              end
              if (c == CH_GT) begin
                mode_next = M_REDIR;
              end else if (c == CH_HASH) begin
                mode_next = M_COMMENT;
              end else begin
                mode_next = M_SKIP;
              end
            end
            CH_SQ:  mode_next = M_SQ;
            CH_DQ:  mode_next = M_DQ;
            CH_BSL: mode_next = M_ESC;
            default: begin
              evs[0] = '{kind: K_BYTE, data: c};
              n = 2'd1;
              word_open_next = 1'b1;
              mode_next = M_WORD;
            end
          endcase
        end
      endcase
    end
  end

  assign push           = fire && (n != 2'd0);
  assign push_entry.two = n[1];
  assign push_entry.ev0 = evs[0];
  assign push_entry.ev1 = evs[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_SKIP;
      word_open <= 1'b0;
    end else if (fire) begin
      mode      <= mode_next;
      word_open <= word_open_next;
    end
  end

endmodule

@@ rtl/slx_queue.sv @@
// Short queue of event bundles between front and back end.
// Depends on slx_pkg.
module slx_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  slx_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output slx_pkg::entry_t head
);
  import slx_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/slx_back.sv @@
// Back end: drains queued bundles into the output register, one event a
// cycle while the output is not stalled. Depends on slx_pkg and slx_out_if.
module slx_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  slx_pkg::entry_t head,
  output logic            pop,
  slx_out_if.source       events
);
  import slx_pkg::*;

  logic   phase;   // 1 while the second event of the head is due
  logic   load;
  logic   is_last;
  event_t cur;

  assign load    = head_valid && (!events.valid || events.ready);
  assign is_last = phase || !head.two;
  assign cur     = phase ? head.ev1 : head.ev0;
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      events.valid <= 1'b0;
      phase        <= 1'b0;
    end else begin
      if (load) begin
        events.valid <= 1'b1;
        phase        <= !is_last;
      end else if (events.ready) begin
        events.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      events.event_kind  <= cur.kind;
      events.word_byte   <= cur.data;
      events.last_of_run <= is_last;
    end
  end

endmodule

@@ rtl/shell_command_lexer_core.sv @@
// Top level of the shell command lexer: front end, bundle queue, back end.
// Depends on slx_pkg, slx_in_if, slx_out_if, slx_front, slx_queue, slx_back.
//
// Usage
//   chars  : one item per command-line byte (char_in), or an end-of-input
//            mark (end_of_input = 1, char_in ignored). valid/ready handshake.
//   events : one item per lexer event: word byte, word end, pipe, redirect
//            truncate, redirect append, line end, input end. last_of_run
//            marks the final event caused by one input item.
//   An input item yields zero, one or two events. Items yielding none
//   (quotes, backslash, skipped spaces, comment bytes) leave no trace.
// Timing
//   An accepted item is written into the queue; its first event is loaded
//   from the queue head into the output register once the output is free.
//   The back end sends one event per cycle while the output is not stalled,
//   and the input is taken every cycle while the queue has room.
// Stalls and reset
//   A stalled output holds its event; the front end keeps accepting until the
//   QUEUE_DEPTH-entry queue fills, then drops chars.ready.
//   Synchronous reset empties the queue, drops events.valid and puts the
//   lexer in skip-spaces mode with no word open.
module shell_command_lexer_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  slx_in_if.sink    chars,
  slx_out_if.source events
);
  import slx_pkg::*;

  logic   push, pop, q_full, q_not_empty;
  entry_t push_entry, head;

  // Lexer state and classification
  slx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Bundles of one or two events per item
  slx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  // Serialise bundles onto the event channel
  slx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_not_empty),
    .head       (head),
    .pop        (pop),
    .events     (events)
  );

endmodule
